### rtl/wwg_pkg.sv
// Shared types and constants for the Wireworld grid engine.
package wwg_pkg;

    localparam int ROWS   = 64;
    localparam int COLS   = 64;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int SWEEP_LAST = CELLS + COLS;
    localparam int CNT_W  = $clog2(SWEEP_LAST + 1);
    localparam int WIN    = 2 * COLS + 3;
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TOGGLE  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CELL_EMPTY = 2'd0,
        CELL_WIRE  = 2'd1,
        CELL_HEAD  = 2'd2,
        CELL_TAIL  = 2'd3
    } t_cell;

    typedef struct packed {
        t_op               op;
        logic              in_grid;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    function automatic logic [1:0] next_cell(input logic [1:0] cur, input logic [3:0] heads);
        logic [1:0] res;
        res = CELL_EMPTY;
        case (cur)
            CELL_WIRE: res = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_WIRE;
            CELL_HEAD: res = CELL_TAIL;
            CELL_TAIL: res = CELL_WIRE;
            default:   res = CELL_EMPTY;
        endcase
        return res;
    endfunction

endpackage

### rtl/wwg_ram.sv
// Generic simple dual-port RAM with registered read.
module wwg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

### rtl/wwg_front.sv
// Command front end: accepts and decodes commands into a short queue.
module wwg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_busy,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_op,
    input  logic [5:0]        i_row,
    input  logic [5:0]        i_column,
    output logic              o_cmd_vld,
    output wwg_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import wwg_pkg::*;

    t_cmd       r_q [CMDQ_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push_ok;

    always_comb begin
        dec.op      = t_op'(i_op);
        dec.in_grid = (int'(i_row) < ROWS) && (int'(i_column) < COLS);
        dec.addr    = dec.in_grid ? ADDR_W'(int'(i_row) * COLS + int'(i_column)) : '0;
    end

    assign o_full    = i_busy || (r_cnt == 2'(CMDQ_DEPTH));
    assign push_ok   = i_push && !o_full;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(i_cmd_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_vld)
        else $error("command pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(CMDQ_DEPTH)) |-> o_full)
        else $error("queue full but not flagged");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(CMDQ_DEPTH))
        else $error("command queue overflow");
endmodule

### rtl/wwg_back.sv
// Command back end: grid memory, generation sweep and result queue.
module wwg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_busy,
    input  logic          i_cmd_vld,
    input  wwg_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [1:0]    o_cell_state
);
    import wwg_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RD    = 4'b0100,
        ST_SWEEP = 4'b1000
    } t_state;

    t_state            r_st, n_st;
    t_cmd              r_cur;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_s1_vld, r_s1_pad, r_s1_ctr, r_s2_vld;
    logic [ADDR_W-1:0] r_wa;
    logic [COL_W-1:0]  r_wcol;
    logic [1:0]        r_win [WIN];
    logic [1:0]        r_ob [2];
    logic              r_owp, r_orp;
    logic [1:0]        r_ocnt;

    logic              we, re, opush;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [1:0]        wdata, q, odata;
    logic [7:0]        nb;
    logic [3:0]        heads;
    logic              last_w, start;

    wwg_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    always_comb begin
        nb[0] = (r_win[0] == CELL_HEAD) && (r_wcol != COL_W'(COLS - 1));
        nb[1] = (r_win[1] == CELL_HEAD);
        nb[2] = (r_win[2] == CELL_HEAD) && (r_wcol != '0);
        nb[3] = (r_win[COLS] == CELL_HEAD) && (r_wcol != COL_W'(COLS - 1));
        nb[4] = (r_win[COLS + 2] == CELL_HEAD) && (r_wcol != '0);
        nb[5] = (r_win[2 * COLS] == CELL_HEAD) && (r_wcol != COL_W'(COLS - 1));
        nb[6] = (r_win[2 * COLS + 1] == CELL_HEAD);
        nb[7] = (r_win[2 * COLS + 2] == CELL_HEAD) && (r_wcol != '0);
        heads = '0;
        for (int i = 0; i < 8; i++) begin
            heads = heads + 4'(nb[i]);
        end
    end

    assign last_w    = (r_wa == ADDR_W'(CELLS - 1));
    assign start     = (r_st == ST_IDLE) && i_cmd_vld && (r_ocnt != 2'd2);
    assign o_cmd_pop = start;
    assign o_busy    = (r_st == ST_INIT);

    always_comb begin
        n_st  = r_st;
        we    = 1'b0;
        waddr = r_wa;
        wdata = CELL_EMPTY;
        re    = 1'b0;
        raddr = r_cnt[ADDR_W-1:0];
        opush = 1'b0;
        odata = CELL_EMPTY;
        unique case (r_st)
            ST_INIT: begin
                we    = 1'b1;
                waddr = r_cnt[ADDR_W-1:0];
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_st  = ST_IDLE;
                    opush = (r_cur.op == OP_CLEAR);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        OP_ADVANCE: n_st = ST_SWEEP;
                        OP_CLEAR:   n_st = ST_INIT;
                        default: begin
                            if (i_cmd.in_grid) begin
                                re    = 1'b1;
                                raddr = i_cmd.addr;
                                n_st  = ST_RD;
                            end else begin
                                opush = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RD: begin
                opush = 1'b1;
                n_st  = ST_IDLE;
                if (r_cur.op == OP_TOGGLE) begin
                    we    = 1'b1;
                    waddr = r_cur.addr;
                    wdata = (q == CELL_EMPTY) ? CELL_WIRE : CELL_EMPTY;
                    odata = wdata;
                end else begin
                    odata = q;
                end
            end
            ST_SWEEP: begin
                re = (r_cnt < CNT_W'(CELLS));
                if (r_s2_vld) begin
                    we    = 1'b1;
                    wdata = next_cell(r_win[COLS + 1], heads);
                    if (last_w) begin
                        opush = 1'b1;
                        n_st  = ST_IDLE;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cur <= i_cmd;
        end
        if (start && i_cmd.op == OP_ADVANCE) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= CELL_EMPTY;
            end
        end else if (r_s1_vld) begin
            r_win[0] <= r_s1_pad ? CELL_EMPTY : q;
            for (int i = 1; i < WIN; i++) begin
                r_win[i] <= r_win[i - 1];
            end
        end
        if (opush) begin
            r_ob[r_owp] <= odata;
        end
        if (!i_rst_n) begin
            r_st     <= ST_INIT;
            r_cur.op <= OP_ADVANCE;
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_s1_pad <= 1'b0;
            r_s1_ctr <= 1'b0;
            r_s2_vld <= 1'b0;
            r_wa     <= '0;
            r_wcol   <= '0;
            r_owp    <= 1'b0;
            r_orp    <= 1'b0;
            r_ocnt   <= 2'd0;
        end else begin
            r_st <= n_st;
            if (start) begin
                r_cnt  <= '0;
                r_wa   <= '0;
                r_wcol <= '0;
            end else if (r_st == ST_INIT) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            if (r_st == ST_SWEEP) begin
                if (r_cnt <= CNT_W'(SWEEP_LAST)) begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_s1_vld <= 1'b1;
                    r_s1_pad <= (r_cnt >= CNT_W'(CELLS));
                    r_s1_ctr <= (r_cnt >= CNT_W'(COLS + 1));
                end
                r_s2_vld <= r_s1_vld && r_s1_ctr;
                if (r_s2_vld) begin
                    r_wa   <= r_wa + 1'b1;
                    r_wcol <= (r_wcol == COL_W'(COLS - 1)) ? '0 : r_wcol + 1'b1;
                end
            end
            if (opush) begin
                r_owp <= ~r_owp;
            end
            if (i_pop && !o_empty) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(opush) - 2'(i_pop && !o_empty);
        end
    end

    assign o_empty      = (r_ocnt == 2'd0);
    assign o_cell_state = r_ob[r_orp];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("grid read and write collide");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        opush |-> (r_ocnt != 2'd2 || (i_pop && !o_empty)))
        else $error("result queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_st != ST_IDLE || r_ocnt != $past(r_ocnt)))
        else $error("command taken but not executed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_st == ST_SWEEP))
        else $error("sweep write outside sweep");
endmodule

### rtl/wireworld_grid_step_top.sv
// Top level of the Wireworld grid engine.
// Usage:
//  Commands enter through a queue port: i_push with i_op, i_row, i_column is
//  taken at a clock edge where i_push is high and o_full is low. Ops: toggle
//  cell, advance generation, clear grid, read cell.
//  Every command yields exactly one transaction on the result queue port:
//  o_cell_state is valid while o_empty is low and is taken when i_pop is high.
//  Toggle and read: the cell is read from the grid RAM and then the result is queued.
//  Advance: one cell per cycle through the single-port-pair grid RAM with a
//  two-row line window.
//  Clear: one RAM write per cycle, one per cell.
//  Two commands may queue ahead of the executing one; results wait in a
//  two-entry queue, and execution stalls only when that queue is full.
//  After reset the grid is cleared with o_full held high; no result is
//  produced for it.
module wireworld_grid_step_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_op,
    input  logic [5:0] i_row,
    input  logic [5:0] i_column,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_cell_state
);
    import wwg_pkg::*;

    t_cmd cmd;
    logic cmd_vld, cmd_pop, busy;

    wwg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_busy    (busy),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_op      (i_op),
        .i_row     (i_row),
        .i_column  (i_column),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    wwg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_busy       (busy),
        .i_cmd_vld    (cmd_vld),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_cell_state (o_cell_state)
    );
endmodule

### tb/tb_top.sv
// Self-checking testbench for the Wireworld grid engine: queued commands, cell predictor.
`timescale 1ns / 1ps

module tb_top;
    import wwg_pkg::*;

    typedef struct {
        t_op        op;
        logic [5:0] row;
        logic [5:0] col;
        bit         drain;
    } t_cmd_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [1:0] i_op = OP_READ;
    logic [5:0] i_row = '0;
    logic [5:0] i_column = '0;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [1:0] o_cell_state;

    t_cmd_item cmd_q[$];
    t_cell     cell_exp_q[$];
    t_cell     grid[64][64];
    int        n_sent = 0;
    int        n_taken = 0;
    int        n_err = 0;
    int        push_gap = 0;
    int        pop_gap = 0;
    bit        quiet = 0;

    wireworld_grid_step_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_op(i_op), .i_row(i_row), .i_column(i_column), .o_empty(o_empty),
        .i_pop(i_pop), .o_cell_state(o_cell_state)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int heads_around(int r, int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < 64 &&
                    c + dc >= 0 && c + dc < 64 && grid[r + dr][c + dc] == CELL_HEAD)
                    n++;
        return n;
    endfunction

    function automatic t_cell run_cmd(t_cmd_item it);
        t_cell nxt[64][64];
        int    h;
        case (it.op)
            OP_TOGGLE: begin
                grid[it.row][it.col] = (grid[it.row][it.col] == CELL_EMPTY) ? CELL_WIRE
                                                                            : CELL_EMPTY;
                return grid[it.row][it.col];
            end
            OP_ADVANCE: begin
                for (int r = 0; r < 64; r++)
                    for (int c = 0; c < 64; c++) begin
                        case (grid[r][c])
                            CELL_WIRE: begin
                                h = heads_around(r, c);
                                nxt[r][c] = (h == 1 || h == 2) ? CELL_HEAD : CELL_WIRE;
                            end
                            CELL_HEAD: nxt[r][c] = CELL_TAIL;
                            CELL_TAIL: nxt[r][c] = CELL_WIRE;
                            default:   nxt[r][c] = CELL_EMPTY;
                        endcase
                    end
                grid = nxt;
                return CELL_EMPTY;
            end
            OP_CLEAR: begin
                foreach (grid[r, c]) grid[r][c] = CELL_EMPTY;
                return CELL_EMPTY;
            end
            default: return grid[it.row][it.col];
        endcase
    endfunction

    function automatic void add_cmd(t_op op, int r, int c, bit drain = 0);
        t_cmd_item it;
        it.op = op;
        it.row = r[5:0];
        it.col = c[5:0];
        it.drain = drain;
        cmd_q.push_back(it);
        n_sent++;
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit nxt_push;
        nxt_push = 0;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                cell_exp_q.push_back(run_cmd(cmd_q.pop_front()));
                n_taken++;
            end
            if (push_gap > 0) begin
                push_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                push_gap = $urandom_range(1, 5);
            end
            if (cmd_q.size() > 0 && cmd_q[0].drain && cell_exp_q.size() == 0)
                cmd_q[0].drain = 0;
            nxt_push = cmd_q.size() > 0 && push_gap == 0 && !cmd_q[0].drain;
            i_push <= nxt_push;
            if (nxt_push) begin
                i_op <= cmd_q[0].op;
                i_row <= cmd_q[0].row;
                i_column <= cmd_q[0].col;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cell want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (cell_exp_q.size() == 0) begin
                    $display("%0t: unexpected transaction, cell_state %0d", $time, o_cell_state);
                    n_err++;
                end else begin
                    want = cell_exp_q.pop_front();
                    if (o_cell_state !== want) begin
                        $display("%0t: cell_state expected %0d actual %0d",
                                 $time, want, o_cell_state);
                        n_err++;
                    end
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop_gap = $urandom_range(1, 5);
            end
            i_pop <= (pop_gap == 0);
        end
    end

    initial begin
        int r, c, k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (grid[gi, gj]) grid[gi][gj] = CELL_EMPTY;

        add_cmd(OP_READ, 0, 0);
        add_cmd(OP_TOGGLE, 0, 0);
        add_cmd(OP_TOGGLE, 63, 63);
        add_cmd(OP_TOGGLE, 0, 63);
        add_cmd(OP_TOGGLE, 63, 0);
        add_cmd(OP_TOGGLE, 42, 21);
        add_cmd(OP_READ, 63, 63);
        add_cmd(OP_READ, 0, 63);
        add_cmd(OP_ADVANCE, 63, 63);
        add_cmd(OP_READ, 0, 0);
        add_cmd(OP_TOGGLE, 63, 0);
        add_cmd(OP_READ, 63, 0);
        add_cmd(OP_READ, 21, 42);
        add_cmd(OP_CLEAR, 21, 42, 1);
        add_cmd(OP_READ, 63, 63);
        add_cmd(OP_READ, 42, 21);

        while (n_sent < 140) begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
            end else begin
                r = $urandom_range(0, 5) + (($urandom_range(0, 1)) ? 58 : 0);
                c = $urandom_range(0, 5) + (($urandom_range(0, 1)) ? 58 : 0);
            end
            if (k < 45)      add_cmd(OP_TOGGLE, r, c);
            else if (k < 88) add_cmd(OP_READ, r, c);
            else if (k < 96) add_cmd(OP_ADVANCE, r, c, $urandom_range(0, 5) == 0);
            else             add_cmd(OP_CLEAR, r, c);
        end

        while (n_taken < n_sent) begin
            @(posedge i_clk);
            if (n_sent - n_taken < 20) quiet = 1;
        end
        while (cell_exp_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_err == 0)
            $display("[wireworld_grid_step_top] OK");
        else
            $display("[wireworld_grid_step_top] ERROR");
        $finish;
    end

    initial begin
        #10000000;
        $display("[wireworld_grid_step_top] ERROR");
        $finish;
    end

endmodule
